// ===== hdl/psd_pkg.sv =====
// shared constants, codes and state type for the penalty score block
package psd_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int SCORE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SCORE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCORE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAR_THRESH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_IVL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PER    = 3'd5;

  localparam int BASE_RESET   = 100;
  localparam int MIN_RESET    = 0;
  localparam int MAX_RESET    = 100;
  localparam int THRESH_RESET = 50;

  localparam logic [1:0] ACT_PENALTY = 2'd0;
  localparam logic [1:0] ACT_REWARD  = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECAY,
    S_APPLY,
    S_SCORE
  } state_e;

endpackage

// ===== hdl/psd_decay_unit.sv =====
// bit-serial divider of elapsed time by the interval with running saturated decay product
module psd_decay_unit import psd_pkg::*; #(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TIME_WIDTH-1:0]  dividend_i,
  input  logic [SCORE_WIDTH-1:0] divisor_i,
  input  logic [SCORE_WIDTH-1:0] per_i,
  output logic                   done_o,
  output logic [SCORE_WIDTH-1:0] rem_o,
  output logic [SCORE_WIDTH:0]   dec_o
);

  localparam int CNT_W = $clog2(TIME_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0]  dvd_q, dvd_d;
  logic [SCORE_WIDTH-1:0] rem_q, rem_d;
  logic [SCORE_WIDTH:0]   acc_q, acc_d;

  logic [SCORE_WIDTH:0]   trial;
  logic                   ge;
  logic [SCORE_WIDTH:0]   trial_sub;
  logic [SCORE_WIDTH+2:0] acc_wide;

  always_comb begin
    trial     = {rem_q, dvd_q[TIME_WIDTH-1]};
    ge        = trial >= {1'b0, divisor_i};
    trial_sub = trial - {1'b0, divisor_i};
    // horner form of quotient times per, msb first, capped at 2^SCORE_WIDTH
    acc_wide  = {1'b0, acc_q, 1'b0} + (ge ? {3'b000, per_i} : '0);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    acc_d  = acc_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(TIME_WIDTH);
      dvd_d  = dividend_i;
      rem_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TIME_WIDTH-2:0], 1'b0};
      rem_d = ge ? trial_sub[SCORE_WIDTH-1:0] : trial[SCORE_WIDTH-1:0];
      if (acc_wide >= {3'b001, {SCORE_WIDTH{1'b0}}}) begin
        acc_d = {1'b1, {SCORE_WIDTH{1'b0}}};
      end else begin
        acc_d = acc_wide[SCORE_WIDTH:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign dec_o  = acc_q;

endmodule

// ===== hdl/psd_score_unit.sv =====
// score from base and penalty, clamped to the range, with quarantine compare
module psd_score_unit import psd_pkg::*; #(
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  logic signed [SCORE_WIDTH-1:0] base_i,
  input  logic signed [SCORE_WIDTH-1:0] lo_i,
  input  logic signed [SCORE_WIDTH-1:0] hi_i,
  input  logic signed [SCORE_WIDTH-1:0] thr_i,
  input  logic        [SCORE_WIDTH-1:0] penalty_i,
  output logic signed [SCORE_WIDTH-1:0] score_o,
  output logic                          quar_o
);

  logic signed [SCORE_WIDTH+1:0] diff;
  logic signed [SCORE_WIDTH+1:0] lo_x;
  logic signed [SCORE_WIDTH+1:0] hi_x;

  always_comb begin
    lo_x = {{2{lo_i[SCORE_WIDTH-1]}}, lo_i};
    hi_x = {{2{hi_i[SCORE_WIDTH-1]}}, hi_i};
    diff = {{2{base_i[SCORE_WIDTH-1]}}, base_i} - $signed({2'b00, penalty_i});
    if (diff < lo_x) begin
      score_o = lo_i;
    end else if (diff > hi_x) begin
      score_o = hi_i;
    end else begin
      score_o = diff[SCORE_WIDTH-1:0];
    end
    quar_o = score_o < thr_i;
  end

endmodule

// ===== hdl/penalty_score_with_decay.sv =====
// top level: config registers, sequencer, penalty state and result register
//
// Leaky-bucket penalty score. Each word on the input channel (action, amount,
// now_time) first decays the stored penalty by whole elapsed decay intervals
// times the per-interval amount, then applies a positive penalty (capped at
// base minus min) or reward (floored at zero), and yields one result word with
// the clamped score, the penalty and the quarantine flag. When decay runs the
// elapsed time is divided by the interval in a bit-serial divider, one quotient
// bit per cycle. One word is worked on at a time; the next is taken while a
// finished result waits to be read. Configuration is written through cfg_we_i /
// cfg_idx_i / cfg_data_i; the user must write it only while idle, as the block
// itself does not enforce this.
module penalty_score_with_decay import psd_pkg::*; #(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [SCORE_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic signed [SCORE_WIDTH-1:0] amount_i,
  input  logic [TIME_WIDTH-1:0]         now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SCORE_WIDTH-1:0] score_out_o,
  output logic [SCORE_WIDTH-1:0]        penalty_out_o,
  output logic                          is_quarantined_o
);

  // config registers
  logic signed [SCORE_WIDTH-1:0] base_cfg_q, min_cfg_q, max_cfg_q, thr_cfg_q, per_cfg_q;
  logic        [SCORE_WIDTH-1:0] ivl_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cfg_q <= SCORE_WIDTH'(BASE_RESET);
      min_cfg_q  <= SCORE_WIDTH'(MIN_RESET);
      max_cfg_q  <= SCORE_WIDTH'(MAX_RESET);
      thr_cfg_q  <= SCORE_WIDTH'(THRESH_RESET);
      ivl_cfg_q  <= '0;
      per_cfg_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_SCORE:  base_cfg_q <= cfg_data_i;
        REG_MIN_SCORE:   min_cfg_q  <= cfg_data_i;
        REG_MAX_SCORE:   max_cfg_q  <= cfg_data_i;
        REG_QUAR_THRESH: thr_cfg_q  <= cfg_data_i;
        REG_DECAY_IVL:   ivl_cfg_q  <= cfg_data_i;
        REG_DECAY_PER:   per_cfg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sanitised config
  logic signed [SCORE_WIDTH-1:0] lo_s, hi_s, base_s, thr_s;
  logic        [SCORE_WIDTH-1:0] per_s;

  always_comb begin
    if (min_cfg_q > max_cfg_q) begin
      lo_s = max_cfg_q;
      hi_s = min_cfg_q;
    end else begin
      lo_s = min_cfg_q;
      hi_s = max_cfg_q;
    end
    if (base_cfg_q < lo_s) begin
      base_s = lo_s;
    end else if (base_cfg_q > hi_s) begin
      base_s = hi_s;
    end else begin
      base_s = base_cfg_q;
    end
    if (thr_cfg_q < lo_s) begin
      thr_s = lo_s;
    end else if (thr_cfg_q > hi_s) begin
      thr_s = hi_s;
    end else begin
      thr_s = thr_cfg_q;
    end
    per_s = per_cfg_q[SCORE_WIDTH-1] ? '0 : per_cfg_q;
  end

  // state
  state_e state_q, state_d;

  logic [SCORE_WIDTH-1:0]        pen_q, pen_d;
  logic [TIME_WIDTH-1:0]         last_q, last_d;
  logic                          out_valid_q, out_valid_d;

  logic [1:0]                    act_q;
  logic signed [SCORE_WIDTH-1:0] amt_q;
  logic [TIME_WIDTH-1:0]         now_q;
  logic signed [SCORE_WIDTH-1:0] lo_q, hi_q, base_q, thr_q;

  logic signed [SCORE_WIDTH-1:0] score_q;
  logic [SCORE_WIDTH-1:0]        pen_out_q;
  logic                          quar_q;

  logic                          in_acc;
  logic                          run_decay;
  logic                          dec_start;
  logic                          dec_done;
  logic [SCORE_WIDTH-1:0]        dec_rem;
  logic [SCORE_WIDTH:0]          dec_val;
  logic [TIME_WIDTH-1:0]         elapsed;

  logic                          amt_pos;
  logic signed [SCORE_WIDTH:0]   cap_w;
  logic [SCORE_WIDTH:0]          pen_sum;
  logic [SCORE_WIDTH:0]          cap_x;

  logic signed [SCORE_WIDTH-1:0] score_c;
  logic                          quar_c;
  logic                          out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign elapsed    = now_time_i - last_q;
  assign run_decay  = (ivl_cfg_q != '0) && (per_s != '0) && (last_q != '0) &&
                      (now_time_i > last_q);
  assign out_free   = !out_valid_q || out_ready_i;

  assign amt_pos = !amt_q[SCORE_WIDTH-1] && (amt_q != '0);
  assign cap_w   = {base_q[SCORE_WIDTH-1], base_q} - {lo_q[SCORE_WIDTH-1], lo_q};
  assign cap_x   = {1'b0, cap_w[SCORE_WIDTH-1:0]};
  assign pen_sum = {1'b0, pen_q} + {1'b0, amt_q};

  psd_decay_unit #(
    .TIME_WIDTH  (TIME_WIDTH),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_decay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dec_start),
    .dividend_i (elapsed),
    .divisor_i  (ivl_cfg_q),
    .per_i      (per_s),
    .done_o     (dec_done),
    .rem_o      (dec_rem),
    .dec_o      (dec_val)
  );

  psd_score_unit #(
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_score (
    .base_i    (base_q),
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .thr_i     (thr_q),
    .penalty_i (pen_q),
    .score_o   (score_c),
    .quar_o    (quar_c)
  );

  always_comb begin
    state_d     = state_q;
    pen_d       = pen_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    dec_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (run_decay) begin
            dec_start = 1'b1;
            state_d   = S_DECAY;
          end else begin
            if (last_q == '0) begin
              last_d = now_time_i;
            end
            state_d = S_APPLY;
          end
        end
      end
      S_DECAY: begin
        if (dec_done) begin
          pen_d   = (dec_val >= {1'b0, pen_q}) ? '0 : pen_q - dec_val[SCORE_WIDTH-1:0];
          last_d  = now_q - TIME_WIDTH'(dec_rem);
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (amt_pos) begin
          case (act_q)
            ACT_PENALTY: pen_d = (pen_sum > cap_x) ? cap_x[SCORE_WIDTH-1:0]
                                                   : pen_sum[SCORE_WIDTH-1:0];
            ACT_REWARD:  pen_d = ($unsigned(amt_q) >= pen_q) ? '0
                                                             : pen_q - $unsigned(amt_q);
            default: ;
          endcase
        end
        state_d = S_SCORE;
      end
      S_SCORE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pen_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pen_q       <= pen_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input word and sanitised config snapshot
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      amt_q  <= amount_i;
      now_q  <= now_time_i;
      lo_q   <= lo_s;
      hi_q   <= hi_s;
      base_q <= base_s;
      thr_q  <= thr_s;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCORE) && out_free) begin
      score_q   <= score_c;
      pen_out_q <= pen_q;
      quar_q    <= quar_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign score_out_o      = score_q;
  assign penalty_out_o    = pen_out_q;
  assign is_quarantined_o = quar_q;

endmodule

// ===== tb/tb_penalty_score_with_decay.sv =====
// self-checking testbench for the penalty score block with decay, driven through both handshakes
module tb_penalty_score_with_decay
  import psd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = TIME_WIDTH_DEF;
  localparam int SW = SCORE_WIDTH_DEF;

  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]           action;
    logic signed [SW-1:0] amount;
    logic [TW-1:0]        now_time;
  } word_t;

  typedef struct packed {
    logic signed [SW-1:0] score;
    logic [SW-1:0]        penalty;
    logic                 quar;
  } score_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SW-1:0]        cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           action_i = '0;
  logic signed [SW-1:0] amount_i = '0;
  logic [TW-1:0]        now_time_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] score_out_o;
  logic [SW-1:0]        penalty_out_o;
  logic                 is_quarantined_o;

  penalty_score_with_decay dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .amount_i         (amount_i),
    .now_time_i       (now_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .score_out_o      (score_out_o),
    .penalty_out_o    (penalty_out_o),
    .is_quarantined_o (is_quarantined_o)
  );

  word_t         pending[$];
  score_t        score_q[$];
  logic [SW-1:0] cfg_regs [0:5];
  longint        penalty_acc;
  logic [TW-1:0] decay_stamp;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            errors = 0;
  int            n_results = 0;
  int            n_added = 0;
  logic          word_taken = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sx(logic [SW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic score_t score_word(word_t w);
    longint lo, hi, tmp, base, thr, per, ivl_l, now_l, stamp_l, steps, dec, amt, nxt, cap, score;
    score_t r;
    lo = sx(cfg_regs[REG_MIN_SCORE]);
    hi = sx(cfg_regs[REG_MAX_SCORE]);
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    base = clip(sx(cfg_regs[REG_BASE_SCORE]), lo, hi);
    thr = clip(sx(cfg_regs[REG_QUAR_THRESH]), lo, hi);
    ivl_l = cfg_regs[REG_DECAY_IVL];
    per = sx(cfg_regs[REG_DECAY_PER]);
    if (per < 0) per = 0;
    now_l = w.now_time;
    stamp_l = decay_stamp;
    if (ivl_l == 0 || per == 0 || stamp_l == 0) begin
      if (stamp_l == 0) decay_stamp = w.now_time;
    end else if (now_l > stamp_l) begin
      steps = (now_l - stamp_l) / ivl_l;
      if (steps != 0) begin
        dec = steps * per;
        penalty_acc = (dec >= penalty_acc) ? 0 : penalty_acc - dec;
        tmp = stamp_l + steps * ivl_l;
        decay_stamp = tmp[TW-1:0];
      end
    end
    amt = sx(w.amount);
    if (amt > 0) begin
      if (w.action == ACT_PENALTY) begin
        cap = base - lo;
        nxt = penalty_acc + amt;
        penalty_acc = (nxt > cap) ? cap : nxt;
      end else if (w.action == ACT_REWARD) begin
        penalty_acc = (amt >= penalty_acc) ? 0 : penalty_acc - amt;
      end
    end
    score = clip(base - penalty_acc, lo, hi);
    r.score = score[SW-1:0];
    r.penalty = penalty_acc[SW-1:0];
    r.quar = (score < thr);
    return r;
  endfunction

  task automatic flag(string what);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $realtime, what);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        {action_i, amount_i, now_time_i} <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin : mon
    score_t exp;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        score_q.insert(score_q.size(), score_word({action_i, amount_i, now_time_i}));
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (score_q.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing outstanding", n_results));
        end else begin
          exp = score_q.pop_front();
          if (score_out_o !== exp.score || penalty_out_o !== exp.penalty ||
              is_quarantined_o !== exp.quar)
            flag($sformatf("result %0d: expected score %0d penalty %0d flag %0b, got %0d %0d %0b",
                           n_results, exp.score, exp.penalty, exp.quar,
                           score_out_o, penalty_out_o, is_quarantined_o));
        end
      end
    end
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [SW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    cfg_regs[idx] = val;
  endtask

  task automatic end_cfg();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_word(logic [1:0] act, logic [SW-1:0] amt, logic [TW-1:0] t);
    pending.insert(pending.size(), word_t'({act, amt, t}));
    n_added++;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (n_results < n_added);
  endtask

  initial begin
    int ph, i, r, span;
    logic [TW-1:0] gen_time;
    logic [SW-1:0] amt;
    logic [1:0] act;
    cfg_regs[REG_BASE_SCORE] = BASE_RESET;
    cfg_regs[REG_MIN_SCORE] = MIN_RESET;
    cfg_regs[REG_MAX_SCORE] = MAX_RESET;
    cfg_regs[REG_QUAR_THRESH] = THRESH_RESET;
    cfg_regs[REG_DECAY_IVL] = '0;
    cfg_regs[REG_DECAY_PER] = '0;
    penalty_acc = 0;
    decay_stamp = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, decay off
    add_word(ACT_TICK, 0, 0);
    add_word(ACT_PENALTY, 30, 5);
    add_word(ACT_PENALTY, 32767, 6);
    add_word(ACT_REWARD, 1, 7);
    add_word(ACT_REWARD, 32767, 8);
    add_word(ACT_PENALTY, 0, 9);
    add_word(ACT_PENALTY, -32768, 10);
    add_word(ACT_REWARD, -1, 11);
    add_word(ACT_SPARE, 50, 12);
    add_word(ACT_PENALTY, 60, 32'hFFFF_FFFF);
    add_word(ACT_TICK, 0, 0);
    drain();

    // decay on, timestamp already running
    put_reg(REG_DECAY_IVL, 10);
    put_reg(REG_DECAY_PER, 5);
    end_cfg();
    add_word(ACT_TICK, 0, 4);
    add_word(ACT_TICK, 0, 5);
    add_word(ACT_TICK, 0, 14);
    add_word(ACT_TICK, 0, 15);
    add_word(ACT_TICK, 0, 47);
    add_word(ACT_PENALTY, 20, 46);
    add_word(ACT_REWARD, 10, 66);
    add_word(ACT_TICK, 0, 32'hFFFF_FFFF);
    add_word(ACT_PENALTY, 100, 0);
    add_word(ACT_SPARE, 7, 32'hFFFF_FFF0);
    drain();

    gen_time = 32'd100;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          put_reg(REG_MIN_SCORE, -32768);
          put_reg(REG_MAX_SCORE, 32767);
          put_reg(REG_BASE_SCORE, 32767);
          put_reg(REG_QUAR_THRESH, 0);
          put_reg(REG_DECAY_IVL, 1);
          put_reg(REG_DECAY_PER, 32767);
        end
        1: begin
          put_reg(REG_MIN_SCORE, 200);
          put_reg(REG_MAX_SCORE, -200);
          put_reg(REG_BASE_SCORE, 1000);
          put_reg(REG_QUAR_THRESH, -1000);
          put_reg(REG_DECAY_IVL, 65535);
          put_reg(REG_DECAY_PER, 1);
        end
        2: begin
          put_reg(REG_MIN_SCORE, 0);
          put_reg(REG_MAX_SCORE, 100);
          put_reg(REG_BASE_SCORE, 50);
          put_reg(REG_QUAR_THRESH, 50);
          put_reg(REG_DECAY_IVL, 7);
          put_reg(REG_DECAY_PER, -5);
        end
        3: begin
          put_reg(REG_MIN_SCORE, $urandom);
          put_reg(REG_MAX_SCORE, $urandom);
          put_reg(REG_BASE_SCORE, $urandom);
          put_reg(REG_QUAR_THRESH, $urandom);
          put_reg(REG_DECAY_IVL, $urandom);
          put_reg(REG_DECAY_PER, $urandom);
        end
        4: begin
          put_reg(REG_MIN_SCORE, 32767);
          put_reg(REG_MAX_SCORE, 32767);
          put_reg(REG_BASE_SCORE, -32768);
          put_reg(REG_QUAR_THRESH, 32767);
          put_reg(REG_DECAY_IVL, 0);
          put_reg(REG_DECAY_PER, 100);
        end
        default: begin
          put_reg(REG_MIN_SCORE, -$urandom_range(0, 500));
          put_reg(REG_MAX_SCORE, $urandom_range(0, 500));
          put_reg(REG_BASE_SCORE, $urandom_range(0, 600));
          put_reg(REG_QUAR_THRESH, $urandom_range(0, 300));
          put_reg(REG_DECAY_IVL, $urandom_range(1, 20));
          put_reg(REG_DECAY_PER, $urandom_range(1, 50));
        end
      endcase
      end_cfg();
      span = (cfg_regs[REG_DECAY_IVL] == 0) ? 10 : int'(cfg_regs[REG_DECAY_IVL]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (i = 0; i < 192; i++) begin
        r = $urandom_range(99);
        if (r < 40) act = ACT_PENALTY;
        else if (r < 75) act = ACT_REWARD;
        else if (r < 95) act = ACT_TICK;
        else act = ACT_SPARE;
        r = $urandom_range(99);
        if (r < 60) amt = $urandom_range(1, 300);
        else if (r < 75) amt = $urandom;
        else if (r < 85) amt = -$urandom_range(0, 40);
        else amt = $urandom_range(1000, 32767);
        r = $urandom_range(99);
        if (r < 80) gen_time += $urandom_range(0, 3 * span + 3);
        else if (r < 87) gen_time -= $urandom_range(0, span + 5);
        else if (r < 95) gen_time = $urandom;
        else gen_time = '0;
        add_word(act, amt, gen_time);
      end
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    repeat (48) @(posedge clk_i);
    if (errors == 0 && score_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/psd_pkg.sv
hdl/psd_decay_unit.sv
hdl/psd_score_unit.sv
hdl/penalty_score_with_decay.sv
tb/tb_penalty_score_with_decay.sv
